[sv/aabb_pkg.sv]
// aabb_pkg: shared widths, constants and controller/datapath link types
`default_nettype none

package aabb_pkg;

  localparam int COORD_W   = 32;
  localparam int FRAC_BITS = 16;

  localparam int NUM_W     = COORD_W + 1;
  localparam int DIV_STEPS = COORD_W - 1;
  localparam int CNT_W     = $clog2(DIV_STEPS);
  localparam int T_W       = (COORD_W > FRAC_BITS + 1) ? COORD_W : FRAC_BITS + 2;
  localparam int TOI_W     = FRAC_BITS + 1;
  localparam int EPS_W     = 16;
  localparam int MAG_CMP_W = (COORD_W > EPS_W) ? COORD_W : EPS_W;

  localparam logic [T_W-1:0] FIX_ONE =
    {{(T_W - FRAC_BITS - 1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};

  localparam logic [EPS_W-1:0] EPS_RESET = 16'd16;

  localparam int PADDR_W   = 3;
  localparam int REG_IDX_W = PADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_EPS = 1'b0;

  typedef struct packed {
    logic load;
    logic eval;
    logic div_step;
    logic order;
    logic window;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic need_div;
    logic last;
  } status_t;

endpackage

`default_nettype wire

[sv/aabb_div.sv]
// aabb_div: radix-2 restoring fixed-point divider with saturation
`default_nettype none

module aabb_div (
  input  logic                          clk_i,
  input  logic                          load_i,
  input  logic                          step_i,
  input  logic [aabb_pkg::NUM_W-1:0]    num_i,
  input  logic [aabb_pkg::COORD_W-1:0]  den_i,
  output logic [aabb_pkg::COORD_W-1:0]  quot_o
);

  localparam int CW     = aabb_pkg::COORD_W;
  localparam int NW     = aabb_pkg::NUM_W;
  localparam int STEPS  = aabb_pkg::DIV_STEPS;
  localparam int WIDE_W = NW + aabb_pkg::FRAC_BITS;
  localparam int TOP_W  = WIDE_W - STEPS;
  localparam int CMP_W  = (TOP_W > CW) ? TOP_W : CW;

  logic [NW-1:0]     n_mag;
  logic [CW-1:0]     d_mag;
  logic [WIDE_W-1:0] wide;
  logic [TOP_W-1:0]  top;
  logic              sat;

  logic [CW-1:0]     d_q;
  logic [CW-1:0]     rem_q;
  logic [STEPS-1:0]  low_q;
  logic [STEPS-1:0]  quo_q;
  logic              neg_q;
  logic              sat_q;

  logic [CW:0]       trial;
  logic [CW:0]       diff;
  logic              ge;
  logic [STEPS-1:0]  mag_r;
  logic [CW-1:0]     pos_r;

  always_comb begin
    n_mag = num_i[NW-1] ? (~num_i + 1'b1) : num_i;
    d_mag = den_i[CW-1] ? (~den_i + 1'b1) : den_i;
    wide  = {n_mag, {aabb_pkg::FRAC_BITS{1'b0}}};
    top   = wide[WIDE_W-1 -: TOP_W];
    sat   = CMP_W'(top) >= CMP_W'(d_mag);
  end

  always_comb begin
    trial = {rem_q, low_q[STEPS-1]};
    diff  = trial - {1'b0, d_q};
    ge    = trial >= {1'b0, d_q};
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      d_q   <= d_mag;
      rem_q <= CW'(top);
      low_q <= wide[STEPS-1:0];
      quo_q <= '0;
      neg_q <= num_i[NW-1] ^ den_i[CW-1];
      sat_q <= sat;
    end else if (step_i) begin
      rem_q <= ge ? diff[CW-1:0] : trial[CW-1:0];
      low_q <= {low_q[STEPS-2:0], 1'b0};
      quo_q <= {quo_q[STEPS-2:0], ge};
    end
  end

  always_comb begin
    mag_r  = sat_q ? {STEPS{1'b1}} : quo_q;
    pos_r  = {1'b0, mag_r};
    quot_o = neg_q ? (~pos_r + 1'b1) : pos_r;
  end

endmodule

`default_nettype wire

[sv/aabb_dp.sv]
// aabb_dp: axis datapath, entry/leave window state and result register
`default_nettype none

module aabb_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  aabb_pkg::cmd_t                cmd_i,
  output aabb_pkg::status_t             status_o,
  input  logic [aabb_pkg::EPS_W-1:0]    eps_i,
  input  logic [aabb_pkg::COORD_W-1:0]  min_a_i,
  input  logic [aabb_pkg::COORD_W-1:0]  max_a_i,
  input  logic [aabb_pkg::COORD_W-1:0]  min_b_i,
  input  logic [aabb_pkg::COORD_W-1:0]  max_b_i,
  input  logic [aabb_pkg::COORD_W-1:0]  velocity_i,
  input  logic                          last_axis_i,
  output logic                          done_o,
  output logic                          hit_o,
  output logic [aabb_pkg::TOI_W-1:0]    toi_o
);

  localparam int CW = aabb_pkg::COORD_W;
  localparam int NW = aabb_pkg::NUM_W;
  localparam int TW = aabb_pkg::T_W;

  logic [CW-1:0] min_a_q, max_a_q, min_b_q, max_b_q, vel_q;
  logic          last_q;
  logic [NW-1:0] num0_q, num1_q;

  logic signed [TW-1:0] t_enter_q, t_leave_q;
  logic signed [TW-1:0] lo_q, hi_q;
  logic                 overlap_q;
  logic                 rejected_q;

  logic                 done_q;
  logic                 hit_q;
  logic [aabb_pkg::TOI_W-1:0] toi_q;

  logic                 axis_ov;
  logic [CW-1:0]        vel_mag;
  logic                 still;
  logic [CW-1:0]        q0, q1;
  logic signed [TW-1:0] q0_ext, q1_ext;
  logic                 q_swap;
  logic signed [TW-1:0] enter_n, leave_n;
  logic                 miss;

  aabb_div u_div0 (
    .clk_i  (clk_i),
    .load_i (cmd_i.eval),
    .step_i (cmd_i.div_step),
    .num_i  (num0_q),
    .den_i  (vel_q),
    .quot_o (q0)
  );

  aabb_div u_div1 (
    .clk_i  (clk_i),
    .load_i (cmd_i.eval),
    .step_i (cmd_i.div_step),
    .num_i  (num1_q),
    .den_i  (vel_q),
    .quot_o (q1)
  );

  always_comb begin
    axis_ov = !(($signed(max_a_q) < $signed(min_b_q)) ||
                ($signed(max_b_q) < $signed(min_a_q)));
    vel_mag = vel_q[CW-1] ? (~vel_q + 1'b1) : vel_q;
    still   = (vel_q == '0) ||
              (aabb_pkg::MAG_CMP_W'(vel_mag) < aabb_pkg::MAG_CMP_W'(eps_i));
    status_o.need_div = !rejected_q && !still;
    status_o.last     = last_q;
  end

  always_comb begin
    q0_ext  = TW'($signed(q0));
    q1_ext  = TW'($signed(q1));
    q_swap  = $signed(q0) > $signed(q1);
    enter_n = (lo_q > t_enter_q) ? lo_q : t_enter_q;
    leave_n = (hi_q < t_leave_q) ? hi_q : t_leave_q;
    miss    = rejected_q || (t_enter_q > $signed(aabb_pkg::FIX_ONE)) ||
              (t_leave_q < 0);
  end

  // beat payload and working values
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      min_a_q <= min_a_i;
      max_a_q <= max_a_i;
      min_b_q <= min_b_i;
      max_b_q <= max_b_i;
      vel_q   <= velocity_i;
      last_q  <= last_axis_i;
      num0_q  <= {min_b_i[CW-1], min_b_i} - {max_a_i[CW-1], max_a_i};
      num1_q  <= {max_b_i[CW-1], max_b_i} - {min_a_i[CW-1], min_a_i};
    end
    if (cmd_i.order) begin
      lo_q <= q_swap ? q1_ext : q0_ext;
      hi_q <= q_swap ? q0_ext : q1_ext;
    end
    if (cmd_i.finish) begin
      hit_q <= overlap_q || !miss;
      toi_q <= (overlap_q || miss || (t_enter_q < 0)) ? '0 :
               t_enter_q[aabb_pkg::TOI_W-1:0];
    end
  end

  // pair state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t_enter_q  <= '0;
      t_leave_q  <= aabb_pkg::FIX_ONE;
      overlap_q  <= 1'b1;
      rejected_q <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      done_q <= cmd_i.finish && last_q;
      if (cmd_i.eval) begin
        if (!axis_ov) begin
          overlap_q <= 1'b0;
        end
        if (!rejected_q && still && !axis_ov) begin
          rejected_q <= 1'b1;
        end
      end
      if (cmd_i.window) begin
        t_enter_q <= enter_n;
        t_leave_q <= leave_n;
        if (enter_n > leave_n) begin
          rejected_q <= 1'b1;
        end
      end
      if (cmd_i.finish && last_q) begin
        t_enter_q  <= '0;
        t_leave_q  <= aabb_pkg::FIX_ONE;
        overlap_q  <= 1'b1;
        rejected_q <= 1'b0;
      end
    end
  end

  assign done_o = done_q;
  assign hit_o  = hit_q;
  assign toi_o  = toi_q;

endmodule

`default_nettype wire

[sv/aabb_ctrl.sv]
// aabb_ctrl: sequencer for one axis beat (evaluate, divide, order, window, finish)
`default_nettype none

module aabb_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  aabb_pkg::status_t status_i,
  output aabb_pkg::cmd_t    cmd_o,
  output logic              busy_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_DIV,
    ST_ORDER,
    ST_WIN,
    ST_FIN
  } state_e;

  state_e                     state_q, state_d;
  logic [aabb_pkg::CNT_W-1:0] cnt_q, cnt_d;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_EVAL;
        end
      end
      ST_EVAL: begin
        cmd_o.eval = 1'b1;
        if (status_i.need_div) begin
          cnt_d   = aabb_pkg::CNT_W'(aabb_pkg::DIV_STEPS - 1);
          state_d = ST_DIV;
        end else begin
          state_d = ST_FIN;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (cnt_q == '0) begin
          state_d = ST_ORDER;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      ST_ORDER: begin
        cmd_o.order = 1'b1;
        state_d     = ST_WIN;
      end
      ST_WIN: begin
        cmd_o.window = 1'b1;
        state_d      = ST_FIN;
      end
      ST_FIN: begin
        cmd_o.finish = 1'b1;
        state_d      = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule

`default_nettype wire

[sv/swept_aabb_toi_top.sv]
// swept_aabb_toi_top: swept box time-of-impact block, config register and wiring
//
//   channel   direction  handshake                  payload
//   config    in/out     psel penable pwrite pready paddr pwdata prdata
//   axis      in         start & !busy              min_a_i max_a_i min_b_i max_b_i
//                                                   velocity_i last_axis_i
//   result    out        done_o (one-cycle strobe)  hit_o toi_o
//
// a moving axis beat keeps busy high through an evaluate state, the steps of the two
// parallel radix-2 dividers (one quotient bit per step, 31 bits), then order, window and
// finish states; a still or already rejected axis goes from evaluate straight to finish.
// the result of a last-axis beat is strobed in the first cycle with busy low,
// and a new beat may be accepted at the edge that ends that cycle. reset clears
// the pair window and sets the threshold to 16. the receiver cannot stall, so
// done_o is never held.
`default_nettype none

module swept_aabb_toi_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [aabb_pkg::PADDR_W-1:0]    paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  input  logic                            start,
  output logic                            busy,
  input  logic [aabb_pkg::COORD_W-1:0]    min_a_i,
  input  logic [aabb_pkg::COORD_W-1:0]    max_a_i,
  input  logic [aabb_pkg::COORD_W-1:0]    min_b_i,
  input  logic [aabb_pkg::COORD_W-1:0]    max_b_i,
  input  logic [aabb_pkg::COORD_W-1:0]    velocity_i,
  input  logic                            last_axis_i,
  output logic                            done_o,
  output logic                            hit_o,
  output logic [aabb_pkg::TOI_W-1:0]      toi_o
);

  logic [aabb_pkg::EPS_W-1:0]     eps_q;
  logic [aabb_pkg::REG_IDX_W-1:0] reg_idx;
  logic                           cfg_wr;
  aabb_pkg::cmd_t                 cmd;
  aabb_pkg::status_t              status;

  assign pready  = 1'b1;
  assign reg_idx = paddr[aabb_pkg::PADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready && (reg_idx == aabb_pkg::REG_EPS);
  assign prdata  = (reg_idx == aabb_pkg::REG_EPS) ? 32'(eps_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eps_q <= aabb_pkg::EPS_RESET;
    end else if (cfg_wr) begin
      eps_q <= pwdata[aabb_pkg::EPS_W-1:0];
    end
  end

  aabb_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy)
  );

  aabb_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .eps_i       (eps_q),
    .min_a_i     (min_a_i),
    .max_a_i     (max_a_i),
    .min_b_i     (min_b_i),
    .max_b_i     (max_b_i),
    .velocity_i  (velocity_i),
    .last_axis_i (last_axis_i),
    .done_o      (done_o),
    .hit_o       (hit_o),
    .toi_o       (toi_o)
  );

endmodule

`default_nettype wire

[tb/sv/tb_top.sv]
// tb_top: self-checking testbench for the swept box time-of-impact block
`timescale 1ns / 1ps

module tb_top;
  import aabb_pkg::*;

  localparam int ONE_Q = 1 << FRAC_BITS;
  localparam logic [PADDR_W-1:0] EPS_ADDR = {REG_EPS, 2'b00};
  localparam longint SAT_Q = (64'sd1 <<< (COORD_W - 1)) - 1;

  typedef struct packed {
    logic             hit;
    logic [TOI_W-1:0] toi;
  } contact_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [PADDR_W-1:0]   paddr = '0;
  logic [31:0]          pwdata = '0;
  logic [31:0]          prdata;
  logic                 pready;
  logic                 start = 1'b0;
  logic                 busy;
  logic [COORD_W-1:0]   min_a_i = '0;
  logic [COORD_W-1:0]   max_a_i = '0;
  logic [COORD_W-1:0]   min_b_i = '0;
  logic [COORD_W-1:0]   max_b_i = '0;
  logic [COORD_W-1:0]   velocity_i = '0;
  logic                 last_axis_i = 1'b0;
  logic                 done_o;
  logic                 hit_o;
  logic [TOI_W-1:0]     toi_o;

  swept_aabb_toi_top dut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .start, .busy, .min_a_i, .max_a_i, .min_b_i, .max_b_i, .velocity_i,
    .last_axis_i, .done_o, .hit_o, .toi_o
  );

  always #5 clk_i = ~clk_i;

  // pair window state of the predictor
  longint      win_enter;
  longint      win_leave;
  bit          all_overlap;
  bit          pair_rejected;
  logic [15:0] motion_eps;

  contact_t expected_contacts[$];
  int err_count = 0;
  int beats_sent = 0;
  int pairs_hit = 0;
  int pairs_missed = 0;
  int contacts_seen = 0;
  int idle_pct = 0;

  task automatic flag_mismatch(input string msg);
    if (err_count < 40) $display("%0t tb_top mismatch: %s", $time, msg);
    err_count++;
  endtask

  function automatic longint abs_q(input longint x);
    return (x < 0) ? -x : x;
  endfunction

  function automatic longint slab_quotient(input longint num, input longint den);
    longint unsigned n, d, qi, rem, q;
    n = abs_q(num);
    d = abs_q(den);
    qi = n / d;
    rem = n % d;
    if (qi > (SAT_Q >> FRAC_BITS)) begin
      q = SAT_Q;
    end else begin
      q = qi;
      for (int i = 0; i < FRAC_BITS; i++) begin
        rem = rem << 1;
        q = q << 1;
        if (rem >= d) begin
          rem = rem - d;
          q = q | 1;
        end
      end
      if (q > SAT_Q) q = SAT_Q;
    end
    return ((num < 0) != (den < 0)) ? -longint'(q) : longint'(q);
  endfunction

  function automatic void clear_window();
    win_enter = 0;
    win_leave = ONE_Q;
    all_overlap = 1'b1;
    pair_rejected = 1'b0;
  endfunction

  task automatic predict_axis(input logic signed [COORD_W-1:0] mina,
                              input logic signed [COORD_W-1:0] maxa,
                              input logic signed [COORD_W-1:0] minb,
                              input logic signed [COORD_W-1:0] maxb,
                              input logic signed [COORD_W-1:0] vel,
                              input logic last);
    longint t0, t1, tmp;
    bit ov;
    contact_t c;
    ov = !(maxa < minb || maxb < mina);
    if (!ov) all_overlap = 1'b0;
    if (!pair_rejected) begin
      if (vel == 0 || abs_q(longint'(vel)) < longint'(motion_eps)) begin
        if (!ov) pair_rejected = 1'b1;
      end else begin
        t0 = slab_quotient(longint'(minb) - longint'(maxa), longint'(vel));
        t1 = slab_quotient(longint'(maxb) - longint'(mina), longint'(vel));
        if (t0 > t1) begin
          tmp = t0;
          t0 = t1;
          t1 = tmp;
        end
        if (t0 > win_enter) win_enter = t0;
        if (t1 < win_leave) win_leave = t1;
        if (win_enter > win_leave) pair_rejected = 1'b1;
      end
    end
    if (last) begin
      if (all_overlap) begin
        c = '{hit: 1'b1, toi: '0};
      end else if (pair_rejected || win_enter > ONE_Q || win_leave < 0) begin
        c = '{hit: 1'b0, toi: '0};
      end else begin
        c.hit = 1'b1;
        c.toi = (win_enter < 0) ? '0 : win_enter[TOI_W-1:0];
      end
      if (c.hit) pairs_hit++;
      else pairs_missed++;
      expected_contacts.push_back(c);
      clear_window();
    end
  endtask

  // result checker
  always @(posedge clk_i) begin
    contact_t want;
    if (rst_ni && done_o === 1'b1) begin
      contacts_seen++;
      if (expected_contacts.size() == 0) begin
        flag_mismatch($sformatf("unexpected result hit=%b toi=%h", hit_o, toi_o));
      end else begin
        want = expected_contacts.pop_front();
        if (hit_o !== want.hit)
          flag_mismatch($sformatf("hit %b, expected %b", hit_o, want.hit));
        if (toi_o !== want.toi)
          flag_mismatch($sformatf("toi %h, expected %h", toi_o, want.toi));
      end
    end
  end

  task automatic send_axis(input logic [COORD_W-1:0] mina, input logic [COORD_W-1:0] maxa,
                           input logic [COORD_W-1:0] minb, input logic [COORD_W-1:0] maxb,
                           input logic [COORD_W-1:0] vel, input logic last);
    bit taken;
    if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      start = 1'b0;
      repeat ($urandom_range(1, 40)) @(negedge clk_i);
    end
    min_a_i = mina;
    max_a_i = maxa;
    min_b_i = minb;
    max_b_i = maxb;
    velocity_i = vel;
    last_axis_i = last;
    start = 1'b1;
    do begin
      @(posedge clk_i);
      taken = (busy === 1'b0);
      if (taken) predict_axis(mina, maxa, minb, maxb, vel, last);
      @(negedge clk_i);
    end while (!taken);
    beats_sent++;
  endtask

  // hold the sender until every expected result is back and the block is idle
  task automatic drain();
    start = 1'b0;
    while (expected_contacts.size() != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
  endtask

  task automatic reg_read_check(input logic [15:0] want);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = EPS_ADDR;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    if (prdata !== {16'h0, want})
      flag_mismatch($sformatf("epsilon read %h, expected %h", prdata, want));
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  task automatic set_epsilon(input logic [15:0] value);
    drain();
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = EPS_ADDR;
    pwdata = {16'($urandom), value};
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    motion_eps = value;
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    reg_read_check(value);
  endtask

  task automatic test_register_reset();
    reg_read_check(EPS_RESET);
  endtask

  task automatic test_directed_slabs();
    // overlapping on every axis, touching on one, whatever the motion
    send_axis(0, 2 * ONE_Q, ONE_Q, 3 * ONE_Q, 5 * ONE_Q, 1'b0);
    send_axis(0, ONE_Q, ONE_Q, 2 * ONE_Q, -3 * ONE_Q, 1'b0);
    send_axis(-ONE_Q, ONE_Q, 0, 0, 0, 1'b1);
    // approach along plus and minus
    send_axis(0, ONE_Q, 2 * ONE_Q, 3 * ONE_Q, 2 * ONE_Q, 1'b1);
    send_axis(2 * ONE_Q, 3 * ONE_Q, 0, ONE_Q, -4 * ONE_Q, 1'b1);
    // still and separated rejects, later axes ignored
    send_axis(0, ONE_Q, 2 * ONE_Q, 3 * ONE_Q, 0, 1'b0);
    send_axis(0, ONE_Q, 2 * ONE_Q, 3 * ONE_Q, 2 * ONE_Q, 1'b1);
    // below threshold
    send_axis(0, ONE_Q, 2 * ONE_Q, 3 * ONE_Q, -15, 1'b1);
    send_axis(0, ONE_Q, 0, ONE_Q, 15, 1'b0);
    send_axis(0, ONE_Q, 2 * ONE_Q, 3 * ONE_Q, 4 * ONE_Q, 1'b1);
    // entry beyond the step, moving apart
    send_axis(0, ONE_Q, 5 * ONE_Q, 6 * ONE_Q, 2 * ONE_Q, 1'b1);
    send_axis(2 * ONE_Q, 3 * ONE_Q, 0, ONE_Q, ONE_Q, 1'b1);
    // saturating quotients at the field extremes
    send_axis(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 16, 1'b1);
    send_axis(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1);
    send_axis(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 1'b1);
    // inverted bounds
    send_axis(3 * ONE_Q, ONE_Q, 2 * ONE_Q, 5 * ONE_Q / 2, ONE_Q, 1'b1);
    // windows on two axes that intersect
    send_axis(0, ONE_Q, 3 * ONE_Q, 4 * ONE_Q, 4 * ONE_Q, 1'b0);
    send_axis(0, ONE_Q, 5 * ONE_Q, 6 * ONE_Q, 5 * ONE_Q, 1'b1);
    // overlapping window on two axes
    send_axis(0, ONE_Q, 2 * ONE_Q, 3 * ONE_Q, 2 * ONE_Q, 1'b0);
    send_axis(0, ONE_Q, 3 * ONE_Q / 2, 3 * ONE_Q, 2 * ONE_Q, 1'b1);
    drain();
  endtask

  task automatic test_epsilon_extremes();
    set_epsilon(16'h0000);
    send_axis(0, ONE_Q, 2 * ONE_Q, 3 * ONE_Q, 0, 1'b1);
    send_axis(0, ONE_Q, ONE_Q + 1, 2 * ONE_Q, 1, 1'b1);
    set_epsilon(16'hffff);
    send_axis(0, ONE_Q, 2 * ONE_Q, 3 * ONE_Q, 32'h0000_fffe, 1'b1);
    send_axis(0, ONE_Q, ONE_Q / 2, 3 * ONE_Q, -32'sd65535, 1'b0);
    send_axis(0, ONE_Q, 2 * ONE_Q, 3 * ONE_Q, 32'h0001_0000, 1'b1);
  endtask

  function automatic logic [COORD_W-1:0] near_q(input int span);
    return COORD_W'(int'($urandom_range(0, 2 * span)) - span);
  endfunction

  task automatic random_axis(input logic last);
    logic [COORD_W-1:0] a_lo, a_hi, b_lo, b_hi, vel, t;
    int kind;
    kind = $urandom_range(0, 19);
    if (kind == 0) begin
      a_lo = $urandom;
      a_hi = $urandom;
      b_lo = $urandom;
      b_hi = $urandom;
    end else begin
      a_lo = near_q(8 * ONE_Q);
      a_hi = a_lo + $urandom_range(0, 3 * ONE_Q);
      b_lo = a_lo + near_q(5 * ONE_Q);
      b_hi = b_lo + $urandom_range(0, 3 * ONE_Q);
      if (kind == 1) begin
        t = a_lo;
        a_lo = a_hi;
        a_hi = t;
      end
    end
    case ($urandom_range(0, 9))
      0:       vel = 0;
      1:       vel = near_q(int'(motion_eps) + 4);
      2:       vel = $urandom;
      default: vel = near_q(6 * ONE_Q);
    endcase
    send_axis(a_lo, a_hi, b_lo, b_hi, vel, last);
  endtask

  task automatic test_random_pairs(input int pct, input logic [15:0] eps, input int count);
    int goal, axes;
    set_epsilon(eps);
    idle_pct = pct;
    goal = beats_sent + count;
    while (beats_sent < goal) begin
      if ($urandom_range(0, 9) == 0) begin
        send_axis($urandom, $urandom, $urandom, $urandom, $urandom, 1'($urandom));
      end else begin
        axes = $urandom_range(1, 3);
        for (int i = 1; i <= axes; i++) random_axis(i == axes);
      end
      if ($urandom_range(0, 49) == 0) drain();
    end
    idle_pct = 0;
  endtask

  initial begin
    clear_window();
    motion_eps = EPS_RESET;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_register_reset();
    test_directed_slabs();
    test_epsilon_extremes();
    test_random_pairs(0, EPS_RESET, 300);
    test_random_pairs(63, 16'h0000, 300);
    test_random_pairs(15, 16'($urandom_range(1, 65534)), 300);
    test_random_pairs(63, 16'hffff, 150);
    start = 1'b0;
    while (expected_contacts.size() != 0) @(negedge clk_i);
    repeat (50) @(negedge clk_i);
    $display("tb_top: %0d axis beats, %0d results checked (%0d hits, %0d misses)",
             beats_sent, contacts_seen, pairs_hit, pairs_missed);
    $display("tb_top: thresholds reset, zero, full scale and random; sender idle 0/15/63%%");
    if (err_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("tb_top: done, errors");
    $finish;
  end

endmodule
